[src/affinity_cross_unique_filter_defines.svh]
// Assertion macros for the cross-unique affinity filter.
// Expects clk_i and rst_ni in the scope of each use; no other dependencies.
`ifndef AFFINITY_CROSS_UNIQUE_FILTER_DEFINES_SVH
`define AFFINITY_CROSS_UNIQUE_FILTER_DEFINES_SVH

// Same-cycle implication, checked at every rising edge outside reset.
`define AFCU_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked at every rising edge outside reset.
`define AFCU_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

[src/afcu_pkg.sv]
// Shared types and constants of the cross-unique affinity filter.
// Used by the controller, the datapath and the top level; no dependencies.
package afcu_pkg;

  localparam int DATA_W    = 16;  // Q5.11 entries and threshold registers
  localparam int IDX_W     = 3;   // row and column index fields
  localparam int DIM_W     = 4;   // num_rows / num_cols registers
  localparam int CFG_IDX_W = 2;

  // Register indexes of the configuration port
  localparam logic [CFG_IDX_W-1:0] CFG_HIGH_THR  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_OTHER_THR = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_NUM_ROWS  = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_NUM_COLS  = 2'd3;

  // 10.0 in Q5.11
  localparam logic signed [DATA_W-1:0] SELECT_VALUE = 16'sd20480;

  // Controller to datapath
  typedef struct packed {
    logic ld_wr;      // store the input item, advance the load position
    logic vis_start;  // walk position to the first entry
    logic vis_next;   // walk position to the next entry, row-major
    logic rd_cur;     // read the entry at the walk position
    logic pos_start;  // restart the column-then-row sweep
    logic scan_step;  // read one sweep entry and check the returned one
    logic wr_step;    // write one sweep entry
    logic out_ld;     // capture the read entry into the output register
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic ld_last;     // load position is the final entry
    logic above_high;  // read entry is above the high threshold
    logic vis_last;    // walk position is the final entry
    logic pos_last;    // sweep position is its final entry
    logic scan_done;   // all sweep reads issued and checked
    logic blocked;     // a competing entry is above the other threshold
  } sts_t;

endpackage

[src/affinity_cross_unique_filter.sv]
// Cross-unique affinity filter top level: controller, datapath and checks.
// Load: one item per cycle while in_ready_o is high. After the last item, the
// filter pass reads each entry in turn; for an entry above the high threshold it
// sweeps reads over the entry's column and row, and writes them when the entry is
// selected. Emit: one result at a time, each held until taken.
// Reset (rst_ni low, asynchronous): thresholds 0, dimensions at maximum,
// load position cleared, block ready for items; matrix contents undefined.
module affinity_cross_unique_filter #(
  parameter int MAX_ROWS = 8,
  parameter int MAX_COLS = 8
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // configuration write port
  input  logic                                cfg_we_i,
  input  logic [afcu_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  logic [afcu_pkg::DATA_W-1:0]         cfg_wdata_i,
  // input items
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic signed [afcu_pkg::DATA_W-1:0]  affinity_value_i,
  // result items
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic signed [afcu_pkg::DATA_W-1:0]  filtered_value_o,
  output logic [afcu_pkg::IDX_W-1:0]          entry_row_o,
  output logic [afcu_pkg::IDX_W-1:0]          entry_col_o,
  output logic                                last_result_o
);
  import afcu_pkg::*;
  `include "affinity_cross_unique_filter_defines.svh"

  cmd_t cmd;
  sts_t sts;

  // Sequence the three phases: take items, filter the stored matrix, emit it
  afcu_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  // Hold the matrix, walk it and compare against the thresholds
  afcu_dp #(
    .MAX_ROWS (MAX_ROWS),
    .MAX_COLS (MAX_COLS)
  ) u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we_i),
    .cfg_idx_i        (cfg_idx_i),
    .cfg_wdata_i      (cfg_wdata_i),
    .affinity_value_i (affinity_value_i),
    .cmd_i            (cmd),
    .sts_o            (sts),
    .filtered_value_o (filtered_value_o),
    .entry_row_o      (entry_row_o),
    .entry_col_o      (entry_col_o),
    .last_result_o    (last_result_o)
  );

  // Loading and emitting never overlap
  `AFCU_ASSERT_NOW(a_load_emit_excl, in_ready_o, !out_valid_o, "ready while a result is shown")
  // The final load item starts the filter pass and closes the input side
  `AFCU_ASSERT_NEXT(a_last_load_stalls, in_valid_i && in_ready_o && sts.ld_last, !in_ready_o, "input still open after final entry")
  // Only the final result reopens the input side
  `AFCU_ASSERT_NEXT(a_mid_emit_closed, out_valid_o && out_ready_i && !last_result_o, !in_ready_o, "input reopened before final result")
  `AFCU_ASSERT_NEXT(a_last_reopens, out_valid_o && out_ready_i && last_result_o, in_ready_o, "input not reopened after final result")

endmodule

[src/afcu_ctrl.sv]
// Sequencer of the cross-unique affinity filter: load, filter pass, emit.
// Depends on afcu_pkg for the command and status structs.
module afcu_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  input  afcu_pkg::sts_t  sts_i,
  output afcu_pkg::cmd_t  cmd_o
);
  import afcu_pkg::*;

  typedef enum logic [2:0] {
    S_LOAD,
    S_VIS_RD,
    S_VIS_CHK,
    S_SCAN,
    S_WRITE,
    S_NEXT,
    S_EM_RD,
    S_EM_HOLD
  } state_e;

  state_e state_q, state_d;
  logic   in_rdy_q, out_vld_q;
  logic   in_rdy_d, out_vld_d;

  always_comb begin
    state_d   = state_q;
    cmd_o     = '0;
    in_rdy_d  = in_rdy_q;
    out_vld_d = out_vld_q;
    unique case (state_q)
      S_LOAD: begin
        if (in_valid_i && in_rdy_q) begin
          cmd_o.ld_wr = 1'b1;
          if (sts_i.ld_last) begin
            cmd_o.vis_start = 1'b1;
            in_rdy_d        = 1'b0;
            state_d         = S_VIS_RD;
          end
        end
      end
      S_VIS_RD: begin
        cmd_o.rd_cur = 1'b1;
        state_d      = S_VIS_CHK;
      end
      S_VIS_CHK: begin
        if (sts_i.above_high) begin
          cmd_o.pos_start = 1'b1;
          state_d         = S_SCAN;
        end else begin
          state_d = S_NEXT;
        end
      end
      S_SCAN: begin
        if (sts_i.scan_done) begin
          if (sts_i.blocked) begin
            state_d = S_NEXT;
          end else begin
            cmd_o.pos_start = 1'b1;
            state_d         = S_WRITE;
          end
        end else begin
          cmd_o.scan_step = 1'b1;
        end
      end
      S_WRITE: begin
        cmd_o.wr_step = 1'b1;
        if (sts_i.pos_last) begin
          state_d = S_NEXT;
        end
      end
      S_NEXT: begin
        if (sts_i.vis_last) begin
          cmd_o.vis_start = 1'b1;
          state_d         = S_EM_RD;
        end else begin
          cmd_o.vis_next = 1'b1;
          state_d        = S_VIS_RD;
        end
      end
      S_EM_RD: begin
        // read issued here; the returned entry is captured into the output register in S_EM_HOLD
        cmd_o.rd_cur = 1'b1;
        state_d      = S_EM_HOLD;
      end
      S_EM_HOLD: begin
        if (!out_vld_q) begin
          cmd_o.out_ld = 1'b1;
          out_vld_d    = 1'b1;
        end else if (out_ready_i) begin
          out_vld_d = 1'b0;
          if (sts_i.vis_last) begin
            in_rdy_d = 1'b1;
            state_d  = S_LOAD;
          end else begin
            cmd_o.vis_next = 1'b1;
            state_d        = S_EM_RD;
          end
        end
      end
      default: begin
        state_d = S_LOAD;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_LOAD;
      in_rdy_q  <= 1'b1;
      out_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      in_rdy_q  <= in_rdy_d;
      out_vld_q <= out_vld_d;
    end
  end

  assign in_ready_o  = in_rdy_q;
  assign out_valid_o = out_vld_q;

endmodule

[src/afcu_dp.sv]
// Datapath of the cross-unique affinity filter: configuration registers,
// matrix memory, position counters, threshold compares and output register.
// Depends on afcu_pkg for widths, register indexes and the command structs.
module afcu_dp #(
  parameter int MAX_ROWS = 8,
  parameter int MAX_COLS = 8
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  cfg_we_i,
  input  logic [afcu_pkg::CFG_IDX_W-1:0]        cfg_idx_i,
  input  logic [afcu_pkg::DATA_W-1:0]           cfg_wdata_i,
  input  logic signed [afcu_pkg::DATA_W-1:0]    affinity_value_i,
  input  afcu_pkg::cmd_t                        cmd_i,
  output afcu_pkg::sts_t                        sts_o,
  output logic signed [afcu_pkg::DATA_W-1:0]    filtered_value_o,
  output logic [afcu_pkg::IDX_W-1:0]            entry_row_o,
  output logic [afcu_pkg::IDX_W-1:0]            entry_col_o,
  output logic                                  last_result_o
);
  import afcu_pkg::*;

  localparam int Depth = MAX_ROWS * MAX_COLS;
  localparam int AddrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam logic [DIM_W-1:0] MaxRows = DIM_W'(MAX_ROWS);
  localparam logic [DIM_W-1:0] MaxCols = DIM_W'(MAX_COLS);

  function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v,
                                                 input logic [DIM_W-1:0] maxv);
    if (v == '0) begin
      return DIM_W'(1);
    end else if (v > maxv) begin
      return maxv;
    end
    return v;
  endfunction

  function automatic logic [AddrW-1:0] addr_of(input logic [IDX_W-1:0] r,
                                               input logic [IDX_W-1:0] c);
    return AddrW'(int'(r) * MAX_COLS + int'(c));
  endfunction

  // Configuration
  logic signed [DATA_W-1:0] hi_thr_q, oth_thr_q;
  logic [DIM_W-1:0]         nr_q, nc_q;
  logic [DIM_W-1:0]         nr_m1, nc_m1;
  logic                     dim_wr;

  // Positions
  logic [IDX_W-1:0] ld_row_q, ld_col_q;
  logic [IDX_W-1:0] vi_q, vj_q;
  logic [IDX_W-1:0] k_q;
  logic             ph_q;          // 0: column sweep, 1: row sweep
  logic             issue_done_q;
  logic             chk_vld_q, chk_self_q, blocked_q;

  logic [IDX_W-1:0] pos_r, pos_c;
  logic             pos_self, k_last;
  logic             ld_last, vis_row_last, vis_col_last;

  // Memory
  logic signed [DATA_W-1:0] mem_q [Depth];
  logic signed [DATA_W-1:0] rd_data_q;
  logic                     wr_en, rd_en;
  logic [AddrW-1:0]         wr_addr, rd_addr;
  logic signed [DATA_W-1:0] wr_data;

  assign dim_wr = cfg_we_i && ((cfg_idx_i == CFG_NUM_ROWS) || (cfg_idx_i == CFG_NUM_COLS));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hi_thr_q  <= '0;
      oth_thr_q <= '0;
      nr_q      <= MaxRows;
      nc_q      <= MaxCols;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_HIGH_THR:  hi_thr_q  <= cfg_wdata_i;
        CFG_OTHER_THR: oth_thr_q <= cfg_wdata_i;
        CFG_NUM_ROWS:  nr_q      <= clamp_dim(cfg_wdata_i[DIM_W-1:0], MaxRows);
        CFG_NUM_COLS:  nc_q      <= clamp_dim(cfg_wdata_i[DIM_W-1:0], MaxCols);
        default: ;
      endcase
    end
  end

  assign nr_m1 = nr_q - DIM_W'(1);
  assign nc_m1 = nc_q - DIM_W'(1);

  assign ld_last      = ({1'b0, ld_row_q} == nr_m1) && ({1'b0, ld_col_q} == nc_m1);
  assign vis_row_last = ({1'b0, vi_q} == nr_m1);
  assign vis_col_last = ({1'b0, vj_q} == nc_m1);

  // Sweep: column of the visited entry first, then its row
  assign pos_r    = ph_q ? vi_q : k_q;
  assign pos_c    = ph_q ? k_q  : vj_q;
  assign pos_self = ph_q ? (k_q == vj_q) : (k_q == vi_q);
  assign k_last   = ph_q ? ({1'b0, k_q} == nc_m1) : ({1'b0, k_q} == nr_m1);

  // Load position; a dimension write drops a partial load
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ld_row_q <= '0;
      ld_col_q <= '0;
    end else if (dim_wr) begin
      ld_row_q <= '0;
      ld_col_q <= '0;
    end else if (cmd_i.ld_wr) begin
      if (ld_last) begin
        ld_row_q <= '0;
        ld_col_q <= '0;
      end else if ({1'b0, ld_col_q} == nc_m1) begin
        ld_col_q <= '0;
        ld_row_q <= ld_row_q + IDX_W'(1);
      end else begin
        ld_col_q <= ld_col_q + IDX_W'(1);
      end
    end
  end

  // Walk position, shared by the filter pass and the emit pass
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vi_q <= '0;
      vj_q <= '0;
    end else if (cmd_i.vis_start) begin
      vi_q <= '0;
      vj_q <= '0;
    end else if (cmd_i.vis_next) begin
      if (vis_col_last) begin
        vj_q <= '0;
        vi_q <= vi_q + IDX_W'(1);
      end else begin
        vj_q <= vj_q + IDX_W'(1);
      end
    end
  end

  // Sweep counter and the pipelined blocking check
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      k_q          <= '0;
      ph_q         <= 1'b0;
      issue_done_q <= 1'b0;
      chk_vld_q    <= 1'b0;
      chk_self_q   <= 1'b0;
      blocked_q    <= 1'b0;
    end else if (cmd_i.pos_start) begin
      k_q          <= '0;
      ph_q         <= 1'b0;
      issue_done_q <= 1'b0;
      chk_vld_q    <= 1'b0;
      blocked_q    <= 1'b0;
    end else begin
      if ((cmd_i.scan_step || cmd_i.wr_step) && !issue_done_q) begin
        if (k_last) begin
          k_q <= '0;
          if (ph_q) begin
            issue_done_q <= 1'b1;
          end else begin
            ph_q <= 1'b1;
          end
        end else begin
          k_q <= k_q + IDX_W'(1);
        end
      end
      if (cmd_i.scan_step) begin
        chk_vld_q  <= !issue_done_q;
        chk_self_q <= pos_self;
        if (chk_vld_q && !chk_self_q && (rd_data_q > oth_thr_q)) begin
          blocked_q <= 1'b1;
        end
      end
    end
  end

  assign wr_en   = cmd_i.ld_wr || cmd_i.wr_step;
  assign wr_addr = cmd_i.ld_wr ? addr_of(ld_row_q, ld_col_q) : addr_of(pos_r, pos_c);
  assign wr_data = cmd_i.ld_wr ? affinity_value_i : (pos_self ? SELECT_VALUE : '0);
  assign rd_en   = cmd_i.rd_cur || (cmd_i.scan_step && !issue_done_q);
  assign rd_addr = cmd_i.rd_cur ? addr_of(vi_q, vj_q) : addr_of(pos_r, pos_c);

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_q <= mem_q[rd_addr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_ld) begin
      filtered_value_o <= rd_data_q;
      entry_row_o      <= vi_q;
      entry_col_o      <= vj_q;
      last_result_o    <= vis_row_last && vis_col_last;
    end
  end

  assign sts_o.ld_last    = ld_last;
  assign sts_o.above_high = (rd_data_q > hi_thr_q);
  assign sts_o.vis_last   = vis_row_last && vis_col_last;
  assign sts_o.pos_last   = ph_q && k_last;
  assign sts_o.scan_done  = issue_done_q && !chk_vld_q;
  assign sts_o.blocked    = blocked_q;

endmodule
